// ===== hdl/dtfp_pkg.sv =====
package dtfp_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// floor(x / 10) == (x * DIV10_MAGIC) >> DIV10_SHIFT for every x below 2^33
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
	localparam int unsigned DIV10_SHIFT = 35;

	localparam int unsigned INT_BITS     = 31;
	localparam int unsigned VALUE_BITS   = 64;
	localparam int unsigned CONSUMED_BITS = 16;
	localparam int unsigned OUT_BITS     = 88;

	typedef enum logic [2:0] {
		K_NONE,
		K_BLANK,
		K_SIGN,
		K_POINT,
		K_DIGIT
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic       neg;
		logic       mark;
		logic       last;
	} op_t;

endpackage

// ===== hdl/dtfp_front.sv =====
module dtfp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     ch,
	input  logic           last,
	input  logic           take,
	output dtfp_pkg::op_t  op
);

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_BODY,
		PH_DONE
	} phase_t;

	phase_t phase_q;
	phase_t phase_next;
	dtfp_pkg::kind_t body_kind;
	logic body_stop;
	logic is_blank;
	logic is_digit;

	always_comb begin
		is_blank = (ch inside {[dtfp_pkg::CH_TAB:dtfp_pkg::CH_CR], dtfp_pkg::CH_SPACE});
		is_digit = (ch inside {[dtfp_pkg::CH_ZERO:dtfp_pkg::CH_NINE]});
		body_stop = 1'b0;
		if (ch == dtfp_pkg::CH_POINT) begin
			body_kind = dtfp_pkg::K_POINT;
		end else if (is_digit) begin
			body_kind = dtfp_pkg::K_DIGIT;
		end else begin
			body_kind = dtfp_pkg::K_NONE;
			body_stop = 1'b1;
		end
	end

	always_comb begin
		op.kind = dtfp_pkg::K_NONE;
		op.digit = 4'(ch - dtfp_pkg::CH_ZERO);
		op.neg = (ch == dtfp_pkg::CH_MINUS);
		op.mark = 1'b0;
		op.last = last;
		phase_next = phase_q;
		case (phase_q)
			PH_SKIP: begin
				if (ch != dtfp_pkg::CH_NUL && is_blank) begin
					op.kind = dtfp_pkg::K_BLANK;
				end else if (ch == dtfp_pkg::CH_MINUS || ch == dtfp_pkg::CH_PLUS) begin
					op.kind = dtfp_pkg::K_SIGN;
					phase_next = PH_BODY;
				end else begin
					op.kind = body_kind;
					op.mark = 1'b1;
					phase_next = body_stop ? PH_DONE : PH_BODY;
				end
			end
			PH_BODY: begin
				op.kind = body_kind;
				phase_next = body_stop ? PH_DONE : PH_BODY;
			end
			default: begin
				op.kind = dtfp_pkg::K_NONE;
			end
		endcase
		if (last) begin
			phase_next = PH_SKIP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
		end else if (take) begin
			phase_q <= phase_next;
		end
	end

endmodule

// ===== hdl/dtfp_queue.sv =====
module dtfp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dtfp_pkg::op_t  push_op,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output dtfp_pkg::op_t  head_op
);

	localparam int unsigned DEPTH = 2;

	dtfp_pkg::op_t mem_q [DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign not_full = (count_q != 2'(DEPTH));
	assign not_empty = (count_q != 2'd0);
	assign head_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/dtfp_back.sv =====
module dtfp_back #(
	parameter int unsigned MAX_LEN = 65535,
	parameter int unsigned FRAC_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	input  dtfp_pkg::op_t                 op,
	output logic                          op_pop,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [dtfp_pkg::OUT_BITS-1:0] res_data
);

	localparam int unsigned FB = FRAC_BITS;
	localparam int unsigned CW = $clog2(64'(MAX_LEN) + 64'd1);
	localparam int unsigned PW = FB + 33;
	localparam int unsigned MW = FB + 5;
	localparam logic [FB:0] STEP_ONE = (FB + 1)'(1) << FB;
	localparam logic [FB:0] STEP_FIRST = STEP_ONE / 10;
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_LEN);
	localparam logic [34:0] INT_SAT = 35'h7FFF_FFFF;

	logic [dtfp_pkg::INT_BITS-1:0] int_q, n_int;
	logic [FB-1:0] frac_q, n_frac;
	logic [FB:0] step_q, n_step;
	logic [CW-1:0] cnt_q, n_cnt, start_q, n_start, cnt_inc;
	logic neg_q, n_neg, point_q, n_point, sat_q, n_sat, began_q, n_began;

	logic [PW-1:0] div_prod;
	logic [FB:0] step_div;
	logic [MW-1:0] frac_sum;
	logic [34:0] int_sum;

	logic valid_s1;
	logic [dtfp_pkg::INT_BITS-1:0] int_s1;
	logic [FB-1:0] frac_s1;
	logic [CW-1:0] cnt_s1;
	logic neg_s1, sat_s1, empty_s1;
	logic adv_s1;

	logic valid_s2;
	logic [dtfp_pkg::OUT_BITS-1:0] data_s2;
	logic [dtfp_pkg::VALUE_BITS-1:0] mag;
	logic [dtfp_pkg::VALUE_BITS-1:0] value;

	assign adv_s1 = !valid_s2 || res_ready;
	assign op_pop = op_valid && (!op.last || !valid_s1 || adv_s1);

	always_comb begin
		div_prod = PW'(step_q) * PW'(dtfp_pkg::DIV10_MAGIC);
		step_div = (FB + 1)'(div_prod >> dtfp_pkg::DIV10_SHIFT);
		frac_sum = MW'(frac_q) + MW'(step_q) * MW'(op.digit);
		int_sum = {int_q, 3'b000} + {3'b000, int_q, 1'b0} + 35'(op.digit);
		cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CW'(1);
	end

	always_comb begin
		n_int = int_q;
		n_frac = frac_q;
		n_step = step_q;
		n_cnt = cnt_q;
		n_start = op.mark ? cnt_q : start_q;
		n_neg = neg_q;
		n_point = point_q;
		n_sat = sat_q;
		n_began = began_q || op.mark;
		case (op.kind)
			dtfp_pkg::K_BLANK: begin
				n_cnt = cnt_inc;
			end
			dtfp_pkg::K_SIGN: begin
				n_cnt = cnt_inc;
				n_start = cnt_inc;
				n_neg = op.neg;
				n_began = 1'b1;
			end
			dtfp_pkg::K_POINT: begin
				n_point = 1'b1;
				n_cnt = cnt_inc;
			end
			dtfp_pkg::K_DIGIT: begin
				n_cnt = cnt_inc;
				if (point_q) begin
					n_step = step_div;
					n_frac = (frac_sum[MW-1:FB] != '0) ? '1 : frac_sum[FB-1:0];
				end else if (int_sum > INT_SAT) begin
					n_int = '1;
					n_sat = 1'b1;
				end else begin
					n_int = int_sum[dtfp_pkg::INT_BITS-1:0];
				end
			end
			default: begin
				n_cnt = cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q <= '0;
			frac_q <= '0;
			step_q <= STEP_FIRST;
			cnt_q <= '0;
			start_q <= '0;
			neg_q <= 1'b0;
			point_q <= 1'b0;
			sat_q <= 1'b0;
			began_q <= 1'b0;
		end else if (op_pop) begin
			if (op.last) begin
				int_q <= '0;
				frac_q <= '0;
				step_q <= STEP_FIRST;
				cnt_q <= '0;
				start_q <= '0;
				neg_q <= 1'b0;
				point_q <= 1'b0;
				sat_q <= 1'b0;
				began_q <= 1'b0;
			end else begin
				int_q <= n_int;
				frac_q <= n_frac;
				step_q <= n_step;
				cnt_q <= n_cnt;
				start_q <= n_start;
				neg_q <= n_neg;
				point_q <= n_point;
				sat_q <= n_sat;
				began_q <= n_began;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && op.last) begin
			int_s1 <= n_int;
			frac_s1 <= n_frac;
			cnt_s1 <= n_cnt;
			neg_s1 <= n_neg;
			sat_s1 <= n_sat;
			empty_s1 <= !n_began || (n_cnt == n_start);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (op_pop && op.last) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		mag = (dtfp_pkg::VALUE_BITS'(int_s1) << FB) | dtfp_pkg::VALUE_BITS'(frac_s1);
		value = neg_s1 ? ('0 - mag) : mag;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			if (empty_s1) begin
				data_s2 <= '0;
			end else begin
				data_s2 <= {7'b0, sat_s1, dtfp_pkg::CONSUMED_BITS'(cnt_s1), value};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	assign res_valid = valid_s2;
	assign res_data = data_s2;

endmodule

// ===== hdl/decimal_text_to_fixed_point.sv =====
// channel  | tvalid/tready     | tdata                               | other
// s_       | character in      | [7:0] ch                            | tlast: last
// m_       | result out        | [63:0] value, [79:64] consumed,     | -
//          |                   | [80] overflow, [87:81] zero         |
// One character per cycle while s_tready is high; the digit unit does one multiply-add per character.
// A result passes from the queue through the back end's s1 and s2 registers to m_.
// arst_n clears the front phase, the queue and all accumulators; no clearing pass.
// A stalled m_ side holds one result and the back end holds one more; characters keep
// flowing until a third last character reaches the back end, then the two-entry queue
// fills and s_tready drops.
module decimal_text_to_fixed_point #(
	parameter int unsigned MAX_LEN = 65535,
	parameter int unsigned FRAC_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] ch
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata   // [63:0] value, [79:64] consumed, [80] overflow
);

	dtfp_pkg::op_t front_op;
	dtfp_pkg::op_t head_op;
	logic take;
	logic q_not_full;
	logic q_not_empty;
	logic q_pop;

	assign s_tready = q_not_full;
	assign take = s_tvalid && q_not_full;

	dtfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (s_tdata),
		.last   (s_tlast),
		.take   (take),
		.op     (front_op)
	);

	dtfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_op   (front_op),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	dtfp_back #(
		.MAX_LEN   (MAX_LEN),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_not_empty),
		.op        (head_op),
		.op_pop    (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata)
	);

endmodule

// ===== hdl/dtfp_checker.sv =====
module dtfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with no result pending");

	a_overflow_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[80] |-> m_tdata[63:0] != 64'd0)
		else $error("overflow flagged on zero value");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[87:81] == 7'd0)
		else $error("result padding not zero");

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
